/* design/assert_macros.svh */
// Assertion macros shared by the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packer assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packer assertion failed");

`endif

/* design/ffrp_pkg.sv */
// Types and constants of the first-fit rectangle packer.
`timescale 1ns / 1ps
package ffrp_pkg;

  localparam int MAX_RECTS = 64;
  localparam int IDX_W     = $clog2(MAX_RECTS);
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);
  localparam int SIDE_W    = 13;
  localparam int CRD_W     = SIDE_W + 1;
  localparam int AREA_W    = 25;
  localparam int GRP       = 8;
  localparam int NGRP      = (MAX_RECTS + GRP - 1) / GRP;
  localparam int CHK_LAT   = 3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BIG   = 2'd2;

  localparam logic [1:0] CFG_MIN_W = 2'd0;
  localparam logic [1:0] CFG_MIN_H = 2'd1;
  localparam logic [1:0] CFG_MAX_W = 2'd2;
  localparam logic [1:0] CFG_MAX_H = 2'd3;

  typedef struct packed {
    logic [12:0] rect_width;
    logic [12:0] rect_height;
    logic        last_rect;
  } in_t;

  typedef struct packed {
    logic [5:0]  rect_index;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic        placed;
    logic [12:0] atlas_width;
    logic [12:0] atlas_height;
    logic [1:0]  status;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [AREA_W-1:0] area;
    logic [IDX_W-1:0]  idx;
    logic [SIDE_W-1:0] px;
    logic [SIDE_W-1:0] py;
  } rect_t;

  typedef struct packed {
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
  } cand_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic place;
    logic check;
  } cell_ctl_t;

endpackage

/* design/ffrp_cell.sv */
// One ring cell: holds a rectangle and its placement, tests a candidate for overlap.
`timescale 1ns / 1ps
module ffrp_cell (
  input  logic                      clk,
  input  ffrp_pkg::cell_ctl_t       ctl,
  input  ffrp_pkg::rect_t           shift_in,
  input  ffrp_pkg::rect_t           ld,
  input  ffrp_pkg::cand_t           cand,
  output ffrp_pkg::rect_t           ent_r,
  output logic [ffrp_pkg::CRD_W-1:0] jump_r
);

  logic [ffrp_pkg::CRD_W:0]   s_xe;
  logic [ffrp_pkg::CRD_W:0]   s_ye;
  logic [ffrp_pkg::CRD_W:0]   c_xe;
  logic [ffrp_pkg::CRD_W:0]   c_ye;
  logic                       hit;
  logic [ffrp_pkg::CRD_W-1:0] jump_nxt;

  assign s_xe = {2'b00, ent_r.px} + {2'b00, ent_r.w};
  assign s_ye = {2'b00, ent_r.py} + {2'b00, ent_r.h};
  assign c_xe = {1'b0, cand.x} + {2'b00, cand.w};
  assign c_ye = {1'b0, cand.y} + {2'b00, cand.h};

  // shared edges count as overlap
  assign hit = ctl.check &&
               !(({1'b0, cand.x} > s_xe) || ({2'b00, ent_r.px} > c_xe) ||
                 ({1'b0, cand.y} > s_ye) || ({2'b00, ent_r.py} > c_ye));

  assign jump_nxt = hit ? ffrp_pkg::CRD_W'(s_xe + 1'b1) : '0;

  always_ff @(posedge clk) begin
    jump_r <= jump_nxt;
    if (ctl.shift) begin
      ent_r <= shift_in;
    end else begin
      if (ctl.load) begin
        ent_r.w    <= ld.w;
        ent_r.h    <= ld.h;
        ent_r.area <= ld.area;
        ent_r.idx  <= ld.idx;
      end
      if (ctl.place) begin
        ent_r.px <= cand.x[ffrp_pkg::SIDE_W-1:0];
        ent_r.py <= cand.y[ffrp_pkg::SIDE_W-1:0];
      end
    end
  end

endmodule

/* design/ffrp_max_tree.sv */
// Two-stage registered maximum over the per-cell jump values.
`timescale 1ns / 1ps
module ffrp_max_tree (
  input  logic                                               clk,
  input  logic [ffrp_pkg::MAX_RECTS-1:0][ffrp_pkg::CRD_W-1:0] leaf,
  output logic [ffrp_pkg::CRD_W-1:0]                         max_r
);

  logic [ffrp_pkg::NGRP-1:0][ffrp_pkg::CRD_W-1:0] grp_r;
  logic [ffrp_pkg::NGRP-1:0][ffrp_pkg::CRD_W-1:0] grp_nxt;
  logic [ffrp_pkg::CRD_W-1:0]                     max_nxt;

  always_comb begin
    for (int g = 0; g < ffrp_pkg::NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < ffrp_pkg::GRP; j++) begin
        if ((g * ffrp_pkg::GRP + j) < ffrp_pkg::MAX_RECTS) begin
          if (leaf[g * ffrp_pkg::GRP + j] > grp_nxt[g]) begin
            grp_nxt[g] = leaf[g * ffrp_pkg::GRP + j];
          end
        end
      end
    end
  end

  always_comb begin
    max_nxt = '0;
    for (int g = 0; g < ffrp_pkg::NGRP; g++) begin
      if (grp_r[g] > max_nxt) begin
        max_nxt = grp_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    max_r <= max_nxt;
  end

endmodule

/* design/first_fit_rect_packer_core.sv */
// Top level of the first-fit scanline rectangle packer.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_stall  ffrp_pkg::in_t
//   out_*        out   out_valid/out_stall ffrp_pkg::out_t
//   cfg_*        in    cfg_we             cfg_idx, cfg_wdata
//
// Loading takes one rectangle per cycle into a ring of MAX_RECTS cells, while in S_LOAD.
// Sorting rotates the ring once per pass, over n + 1 passes.
// Each candidate position is set up in S_CAND, then waits in S_CHK on the overlap
// tree; moving to the next row takes a further S_CAND step.
// Input is stalled from the final rectangle until the last result is loaded.
// Reset is synchronous; it clears control state and restores the registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_rect_packer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ffrp_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ffrp_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [ffrp_pkg::SIDE_W-1:0]  cfg_wdata
);

  localparam int N = ffrp_pkg::MAX_RECTS;
  localparam int IW = ffrp_pkg::IDX_W;
  localparam int CW = ffrp_pkg::CNT_W;
  localparam int SW = ffrp_pkg::SIDE_W;
  localparam int DW = ffrp_pkg::CRD_W;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_SORT  = 8'b0000_0010,
    S_HSTEP = 8'b0000_0100,
    S_WSTEP = 8'b0000_1000,
    S_FETCH = 8'b0001_0000,
    S_CAND  = 8'b0010_0000,
    S_CHK   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r;

  logic [SW-1:0] min_w_r, min_h_r, max_w_r, max_h_r;
  logic [SW-1:0] min_w_eff, min_h_eff;

  logic [CW-1:0] cnt_r, n_r, pi_r, prev_i_r, k_r, pn_r, kout_r;
  logic [IW-1:0] rot_r, cbpos_r, pbpos_r;
  logic          big_r, found_r, sub_v_r;
  ffrp_pkg::rect_t cb_r, ci_r, pb_r, pival_r;
  ffrp_pkg::rect_t cb_nxt, ci_nxt;
  logic [IW-1:0]   cbpos_nxt;

  logic [DW-1:0] ch_r, cw_r, x_r, y_r;
  logic [SW-1:0] aw_r, ah_r, cur_w_r, cur_h_r;
  logic [1:0]    chk_cnt_r;

  ffrp_pkg::out_t out_r;
  logic           out_valid_r;

  ffrp_pkg::rect_t [N-1:0]           ent;
  ffrp_pkg::rect_t [N-1:0]           shin;
  ffrp_pkg::cell_ctl_t [N-1:0]       ctl;
  logic [N-1:0][DW-1:0]              jumps;
  logic [DW-1:0]                     max_jump;
  ffrp_pkg::rect_t                   ld, head_eff, tail_in;
  ffrp_pkg::cand_t                   cand;

  logic          accept, stored, this_big, ring_shift, emit, place_ev;
  logic          in_scan, rot_end, y_ok, x_ok;
  logic [2*SW-1:0] prod;
  logic [CW-1:0] pos;

  assign min_w_eff = (min_w_r == '0) ? SW'(1) : min_w_r;
  assign min_h_eff = (min_h_r == '0) ? SW'(1) : min_h_r;

  assign in_stall = !rst_n || (state_r != S_LOAD);
  assign accept   = in_valid && !in_stall;
  assign stored   = accept && (cnt_r < CW'(N));
  assign this_big = (in_data.rect_width > max_w_r) || (in_data.rect_height > max_h_r);

  assign prod     = {{SW{1'b0}}, in_data.rect_width} * {{SW{1'b0}}, in_data.rect_height};
  assign ld.w     = in_data.rect_width;
  assign ld.h     = in_data.rect_height;
  assign ld.area  = prod[ffrp_pkg::AREA_W-1:0];
  assign ld.idx   = cnt_r[IW-1:0];
  assign ld.px    = '0;
  assign ld.py    = '0;

  assign cand.x = x_r;
  assign cand.y = y_r;
  assign cand.w = cur_w_r;
  assign cand.h = cur_h_r;

  // sort: apply the previous pass's swap as entries come past the head
  assign pos = CW'(rot_r);
  always_comb begin
    head_eff = ent[0];
    if (sub_v_r && pos == prev_i_r) begin
      head_eff = pb_r;
    end else if (sub_v_r && rot_r == pbpos_r) begin
      head_eff = pival_r;
    end
  end

  assign in_scan = (pos >= pi_r) && (pos < n_r);
  always_comb begin
    cb_nxt    = cb_r;
    ci_nxt    = ci_r;
    cbpos_nxt = cbpos_r;
    if (in_scan && pos == pi_r) begin
      cb_nxt    = head_eff;
      ci_nxt    = head_eff;
      cbpos_nxt = rot_r;
    end else if (in_scan && head_eff.area > cb_r.area) begin
      cb_nxt    = head_eff;
      cbpos_nxt = rot_r;
    end
  end

  assign rot_end    = (rot_r == IW'(N - 1));
  assign emit       = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign ring_shift = (state_r == S_SORT) || emit;
  assign tail_in    = (state_r == S_SORT) ? head_eff : ent[0];
  assign place_ev   = (state_r == S_CHK) && (chk_cnt_r == 2'(ffrp_pkg::CHK_LAT)) &&
                      (max_jump == '0);

  assign y_ok = (y_r < {1'b0, ah_r}) &&
                (({1'b0, y_r} + {2'b00, cur_h_r}) <= {2'b00, ah_r});
  assign x_ok = (x_r < {1'b0, aw_r}) &&
                (({1'b0, x_r} + {2'b00, cur_w_r}) <= {2'b00, aw_r});

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      assign shin[i] = tail_in;
    end else begin : g_mid
      assign shin[i] = ent[i+1];
    end
    assign ctl[i].shift = ring_shift;
    assign ctl[i].load  = stored && (cnt_r == CW'(i));
    assign ctl[i].place = place_ev && (k_r == CW'(i));
    assign ctl[i].check = (k_r > CW'(i));

    ffrp_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .shift_in (shin[i]),
      .ld       (ld),
      .cand     (cand),
      .ent_r    (ent[i]),
      .jump_r   (jumps[i])
    );
  end

  ffrp_max_tree u_tree (
    .clk   (clk),
    .leaf  (jumps),
    .max_r (max_jump)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_w_r <= SW'(256);
      min_h_r <= SW'(256);
      max_w_r <= SW'(1024);
      max_h_r <= SW'(1024);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ffrp_pkg::CFG_MIN_W: min_w_r <= cfg_wdata;
        ffrp_pkg::CFG_MIN_H: min_h_r <= cfg_wdata;
        ffrp_pkg::CFG_MAX_W: max_w_r <= cfg_wdata;
        ffrp_pkg::CFG_MAX_H: max_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // payload-side working registers
  always_ff @(posedge clk) begin
    if (state_r == S_SORT) begin
      cb_r    <= cb_nxt;
      ci_r    <= ci_nxt;
      cbpos_r <= cbpos_nxt;
      if (rot_end) begin
        pb_r     <= cb_nxt;
        pival_r  <= ci_nxt;
        pbpos_r  <= cbpos_nxt;
        prev_i_r <= pi_r;
      end
    end
    if (state_r == S_FETCH) begin
      cur_w_r <= ent[k_r[IW-1:0]].w;
      cur_h_r <= ent[k_r[IW-1:0]].h;
    end
    if (emit) begin
      out_r.rect_index   <= 6'(ent[0].idx);
      out_r.placed       <= (kout_r < pn_r);
      out_r.pos_x        <= (kout_r < pn_r) ? ent[0].px[11:0] : 12'd0;
      out_r.pos_y        <= (kout_r < pn_r) ? ent[0].py[11:0] : 12'd0;
      out_r.atlas_width  <= aw_r;
      out_r.atlas_height <= ah_r;
      out_r.status       <= big_r ? ffrp_pkg::ST_BIG :
                            (found_r ? ffrp_pkg::ST_OK : ffrp_pkg::ST_NOFIT);
      out_r.last_result  <= (kout_r + 1'b1 == n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      n_r         <= '0;
      big_r       <= 1'b0;
      found_r     <= 1'b0;
      sub_v_r     <= 1'b0;
      pi_r        <= '0;
      rot_r       <= '0;
      k_r         <= '0;
      pn_r        <= '0;
      kout_r      <= '0;
      chk_cnt_r   <= '0;
      ch_r        <= '0;
      cw_r        <= '0;
      x_r         <= '0;
      y_r         <= '0;
      aw_r        <= '0;
      ah_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (accept && in_data.last_rect) begin
            n_r     <= stored ? cnt_r + 1'b1 : cnt_r;
            cnt_r   <= '0;
            big_r   <= big_r || (stored && this_big);
            found_r <= 1'b0;
            pn_r    <= '0;
            aw_r    <= max_w_r;
            ah_r    <= max_h_r;
            pi_r    <= '0;
            rot_r   <= '0;
            sub_v_r <= 1'b0;
            kout_r  <= '0;
            state_r <= (big_r || (stored && this_big)) ? S_OUT : S_SORT;
          end else if (stored) begin
            cnt_r <= cnt_r + 1'b1;
            if (this_big) begin
              big_r <= 1'b1;
            end
          end
        end
        S_SORT: begin
          rot_r <= rot_end ? '0 : rot_r + 1'b1;
          if (rot_end) begin
            if (pi_r == n_r) begin
              sub_v_r <= 1'b0;
              ch_r    <= {1'b0, min_h_eff};
              state_r <= S_HSTEP;
            end else begin
              pi_r    <= pi_r + 1'b1;
              sub_v_r <= 1'b1;
            end
          end
        end
        S_HSTEP: begin
          if (ch_r <= {1'b0, max_h_r}) begin
            ah_r    <= ch_r[SW-1:0];
            cw_r    <= {1'b0, min_w_eff};
            state_r <= S_WSTEP;
          end else begin
            kout_r  <= '0;
            state_r <= S_OUT;
          end
        end
        S_WSTEP: begin
          if (cw_r <= {1'b0, max_w_r}) begin
            aw_r    <= cw_r[SW-1:0];
            k_r     <= '0;
            state_r <= S_FETCH;
          end else begin
            ch_r    <= ch_r << 1;
            state_r <= S_HSTEP;
          end
        end
        S_FETCH: begin
          x_r     <= '0;
          y_r     <= '0;
          state_r <= S_CAND;
        end
        S_CAND: begin
          if (!y_ok) begin
            pn_r    <= k_r;
            cw_r    <= cw_r << 1;
            state_r <= S_WSTEP;
          end else if (!x_ok) begin
            y_r <= y_r + 1'b1;
            x_r <= '0;
          end else begin
            chk_cnt_r <= '0;
            state_r   <= S_CHK;
          end
        end
        S_CHK: begin
          if (chk_cnt_r == 2'(ffrp_pkg::CHK_LAT)) begin
            if (max_jump == '0) begin
              if (k_r + 1'b1 == n_r) begin
                found_r <= 1'b1;
                pn_r    <= n_r;
                kout_r  <= '0;
                state_r <= S_OUT;
              end else begin
                k_r     <= k_r + 1'b1;
                state_r <= S_FETCH;
              end
            end else begin
              x_r     <= max_jump;
              state_r <= S_CAND;
            end
          end else begin
            chk_cnt_r <= chk_cnt_r + 1'b1;
          end
        end
        S_OUT: begin
          if (emit) begin
            kout_r <= kout_r + 1'b1;
            if (kout_r + 1'b1 == n_r) begin
              big_r   <= 1'b0;
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMP(a_emit_in_range, emit, kout_r < n_r)
  `ASSERT_IMP(a_check_in_range, state_r == S_CHK, k_r < n_r)
  `ASSERT_IMP(a_place_inside, place_ev, (({1'b0, x_r} + {2'b00, cur_w_r}) <= {2'b00, aw_r}))
  `ASSERT_NXT(a_sort_aligned, state_r == S_SORT && rot_end && pi_r == n_r, rot_r == '0)

endmodule
